FILE: sv/cgp_pkg.sv
// Shared types, codes and constants of the CGP gate-array evaluator.
// No dependencies; used by cgp_gate_array_evaluator_top, cgp_row_checker and the testbench.

package cgp_pkg;

    // Default array limits
    localparam int unsigned DEF_MAX_INPUTS  = 8;
    localparam int unsigned DEF_MAX_NODES   = 64;
    localparam int unsigned DEF_MAX_OUTPUTS = 8;

    // Field widths fixed by the item format
    localparam int unsigned ADDR_W   = 8;
    localparam int unsigned GENE_W   = 7;
    localparam int unsigned BITS_W   = 8;
    localparam int unsigned OUT_BITS = 8;
    localparam int unsigned OCW      = 3;   // output index width
    localparam int unsigned NOW      = 4;   // output count width (0..8)
    localparam int unsigned FIT_W    = 12;
    localparam logic [FIT_W-1:0] FIT_MAX = '1;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 2'd2;
    localparam logic [3:0] RST_NUM_INPUTS  = 4'd8;
    localparam logic [6:0] RST_NUM_NODES   = 7'd64;
    localparam logic [3:0] RST_NUM_OUTPUTS = 4'd8;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // Gate function codes; every other code is XOR
    localparam logic [GENE_W-1:0] FN_AND = 7'd1;
    localparam logic [GENE_W-1:0] FN_OR  = 7'd2;
    localparam logic [GENE_W-1:0] FN_NOT = 7'd3;

    // Genome banks: gene position modulo three
    localparam int unsigned GENE_BANKS = 3;
    localparam logic [1:0] BANK_SRC_A = 2'd0;
    localparam logic [1:0] BANK_SRC_B = 2'd1;
    localparam logic [1:0] BANK_FUNC  = 2'd2;

    // Reciprocal of three for 8-bit addresses: floor(a * 171 / 512)
    localparam logic [16:0] DIV3_MUL = 17'd171;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] gene_addr;
        logic [GENE_W-1:0] gene_value;
        logic [BITS_W-1:0] input_bits;
        logic [BITS_W-1:0] expected_bits;
        logic              last_row;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] output_bits;
        logic [NOW-1:0]      row_matches;
        logic [FIT_W-1:0]    fitness_total;
        logic                pass_done;
    } t_out_item;

    // Gene position divided by three (row within a bank)
    function automatic logic [6:0] div3(input logic [ADDR_W-1:0] a);
        logic [16:0] p;
        p = 17'(a) * DIV3_MUL;
        return p[15:9];
    endfunction

endpackage

FILE: sv/cgp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module cgp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cgp_gate_array_evaluator_top.sv
// CGP gate-array evaluator: a gene write gives no result. An evaluate item first
// stores its inputs in the value store, then issues one node or output pick at a time
// through the genome banks and value store, and drains the pipeline before o_valid
// rises. One item is in work at a time: o_stall holds off the next transfer until the
// result is loaded.
// Synchronous active-low reset sets registers to 8/64/8, slots read one, fitness zero.

module cgp_gate_array_evaluator_top #(
    parameter int unsigned MAX_INPUTS  = cgp_pkg::DEF_MAX_INPUTS,
    parameter int unsigned MAX_NODES   = cgp_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_OUTPUTS = cgp_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  cgp_pkg::t_in_item                  i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output cgp_pkg::t_out_item                 o_data,
    input  logic                               i_cfg_we,
    input  logic [cgp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cgp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Derived sizes
    localparam int unsigned SD      = MAX_INPUTS + MAX_NODES;           // value slots
    localparam int unsigned GD      = 3 * MAX_NODES + MAX_OUTPUTS;      // genes
    localparam int unsigned GR      = MAX_NODES + (MAX_OUTPUTS + 2) / 3; // bank rows
    localparam int unsigned SW      = $clog2(SD);
    localparam int unsigned GRW     = $clog2(GR);
    localparam int unsigned NIW     = $clog2(MAX_INPUTS + 1);
    localparam int unsigned NNW     = $clog2(MAX_NODES + 1);
    localparam int unsigned OUT_LIM = (MAX_OUTPUTS < cgp_pkg::OUT_BITS) ?
                                      MAX_OUTPUTS : cgp_pkg::OUT_BITS;
    localparam int unsigned GENE_BANKS_W = cgp_pkg::GENE_BANKS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DRAIN
    } t_state;

    // Control
    t_state                        r_state;
    logic [3:0]                    r_cfg_ni;
    logic [6:0]                    r_cfg_nn;
    logic [3:0]                    r_cfg_no;
    logic [NIW-1:0]                r_ni;
    logic [NNW-1:0]                r_nn;
    logic [cgp_pkg::NOW-1:0]       r_no;
    logic [NIW-1:0]                r_jcnt;
    logic [NNW-1:0]                r_kcnt;
    logic                          r_omode;
    logic [GRW-1:0]                r_orow;
    logic [1:0]                    r_obank;
    logic [cgp_pkg::OCW-1:0]       r_ocnt;
    logic [SD-1:0]                 r_vld;
    logic [cgp_pkg::FIT_W-1:0]     r_fit;
    logic                          r_ovld;
    logic                          r_p1_vld;
    logic                          r_p2_vld;

    // Row payload
    logic [cgp_pkg::BITS_W-1:0]    r_ibits;
    logic [cgp_pkg::BITS_W-1:0]    r_ebits;
    logic                          r_last;
    logic [cgp_pkg::OUT_BITS-1:0]  r_obits;
    logic [cgp_pkg::NOW-1:0]       r_match;
    cgp_pkg::t_out_item            r_odata;

    // Pipeline payload: stage 1 (genome data out), stage 2 (value data out)
    logic                          r_p1_out;
    logic [1:0]                    r_p1_bank;
    logic [cgp_pkg::OCW-1:0]       r_p1_oidx;
    logic [SW-1:0]                 r_p1_slot;
    logic                          r_p2_out;
    logic [cgp_pkg::OCW-1:0]       r_p2_oidx;
    logic [SW-1:0]                 r_p2_slot;
    logic [cgp_pkg::GENE_W-1:0]    r_p2_func;
    logic                          r_p2_rng_a;
    logic                          r_p2_rng_b;
    logic                          r_p2_vbit_a;
    logic                          r_p2_vbit_b;
    logic                          r_p2_hit_a;
    logic                          r_p2_hit_b;
    logic                          r_p2_fwd;

    // Combinational
    logic                          w_in_acc;
    logic                          w_out_acc;
    logic                          w_load;
    logic [NIW-1:0]                w_ni;
    logic [NNW-1:0]                w_nn;
    logic [cgp_pkg::NOW-1:0]       w_no;
    logic [6:0]                    w_gq_row;
    logic [1:0]                    w_grem;
    logic [GENE_BANKS_W-1:0]       w_gwe;
    logic [GRW-1:0]                w_rd_row;
    logic [cgp_pkg::GENE_W-1:0]    w_gq [cgp_pkg::GENE_BANKS];
    logic [cgp_pkg::GENE_W-1:0]    w_src_a;
    logic [cgp_pkg::GENE_W-1:0]    w_src_b;
    logic                          w_rng_a;
    logic                          w_rng_b;
    logic [SW-1:0]                 w_rda;
    logic [SW-1:0]                 w_rdb;
    logic                          w_qa;
    logic                          w_qb;
    logic                          w_a;
    logic                          w_b;
    logic                          w_v;
    logic [cgp_pkg::BITS_W-1:0]    w_ibits_sh;
    logic                          w_wr_en;
    logic [SW-1:0]                 w_wr_addr;
    logic                          w_wr_data;
    logic [cgp_pkg::FIT_W:0]       w_fit_sum;
    logic [cgp_pkg::FIT_W-1:0]     w_fit_total;

    // Handshakes
    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign o_valid   = r_ovld;
    assign o_data    = r_odata;
    assign w_out_acc = r_ovld && !i_stall;
    assign w_load    = (r_state == S_DRAIN) && !r_p1_vld && !r_p2_vld &&
                       (!r_ovld || !i_stall);

    // Clamp the configuration to its effective ranges
    always_comb begin
        if (r_cfg_ni == '0) begin
            w_ni = NIW'(1);
        end else if (32'(r_cfg_ni) > MAX_INPUTS) begin
            w_ni = NIW'(MAX_INPUTS);
        end else begin
            w_ni = NIW'(r_cfg_ni);
        end
        if (r_cfg_nn == '0) begin
            w_nn = NNW'(1);
        end else if (32'(r_cfg_nn) > MAX_NODES) begin
            w_nn = NNW'(MAX_NODES);
        end else begin
            w_nn = NNW'(r_cfg_nn);
        end
        if (r_cfg_no == '0) begin
            w_no = cgp_pkg::NOW'(1);
        end else if (32'(r_cfg_no) > OUT_LIM) begin
            w_no = cgp_pkg::NOW'(OUT_LIM);
        end else begin
            w_no = cgp_pkg::NOW'(r_cfg_no);
        end
    end

    // Split a gene position into bank (position mod 3) and row (position / 3)
    assign w_gq_row = cgp_pkg::div3(i_data.gene_addr);
    assign w_grem   = 2'(i_data.gene_addr - {w_gq_row, 1'b0} - {1'b0, w_gq_row});

    always_comb begin
        for (int g = 0; g < GENE_BANKS_W; g++) begin
            w_gwe[g] = w_in_acc && (i_data.kind == cgp_pkg::KIND_WRITE) &&
                       (32'(i_data.gene_addr) < GD) && (w_grem == 2'(g));
        end
    end

    // Issue row: node k, or the row holding output gene 3*nn + k
    assign w_rd_row = r_omode ? r_orow : GRW'(r_kcnt);

    for (genvar g = 0; g < GENE_BANKS_W; g++) begin : g_bank
        cgp_ram #(
            .WIDTH (cgp_pkg::GENE_W),
            .DEPTH (GR)
        ) u_gene_ram (
            .i_clk   (i_clk),
            .i_we    (w_gwe[g]),
            .i_waddr (GRW'(w_gq_row)),
            .i_wdata (i_data.gene_value),
            .i_raddr (w_rd_row),
            .o_rdata (w_gq[g])
        );
    end

    // Stage 1: pick source indexes from the genome data and check range
    always_comb begin
        if (r_p1_out) begin
            unique case (r_p1_bank)
                cgp_pkg::BANK_SRC_A: w_src_a = w_gq[0];
                cgp_pkg::BANK_SRC_B: w_src_a = w_gq[1];
                default:             w_src_a = w_gq[2];
            endcase
        end else begin
            w_src_a = w_gq[0];
        end
        w_src_b = w_gq[1];
        w_rng_a = (32'(w_src_a) < SD);
        w_rng_b = (32'(w_src_b) < SD);
        w_rda   = SW'(w_src_a);
        w_rdb   = SW'(w_src_b);
    end

    // Value store, duplicated for two read ports
    cgp_ram #(
        .WIDTH (1),
        .DEPTH (SD)
    ) u_val_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (w_rda),
        .o_rdata (w_qa)
    );

    cgp_ram #(
        .WIDTH (1),
        .DEPTH (SD)
    ) u_val_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (w_rdb),
        .o_rdata (w_qb)
    );

    // Stage 2: resolve operands (range, same-cycle forward, never written), apply gate
    always_comb begin
        if (!r_p2_rng_a) begin
            w_a = 1'b0;
        end else if (r_p2_hit_a) begin
            w_a = r_p2_fwd;
        end else if (!r_p2_vbit_a) begin
            w_a = 1'b1;
        end else begin
            w_a = w_qa;
        end
        if (!r_p2_rng_b) begin
            w_b = 1'b0;
        end else if (r_p2_hit_b) begin
            w_b = r_p2_fwd;
        end else if (!r_p2_vbit_b) begin
            w_b = 1'b1;
        end else begin
            w_b = w_qb;
        end
        unique case (r_p2_func)
            cgp_pkg::FN_AND: w_v = w_a & w_b;
            cgp_pkg::FN_OR:  w_v = w_a | w_b;
            cgp_pkg::FN_NOT: w_v = ~w_a;
            default:         w_v = w_a ^ w_b;
        endcase
    end

    // Value store write: input placement, then node results
    assign w_ibits_sh = r_ibits >> r_jcnt;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = SW'(r_jcnt);
        w_wr_data = w_ibits_sh[0];
        if (r_state == S_LOAD) begin
            w_wr_en = 1'b1;
        end else if (r_p2_vld && !r_p2_out) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_p2_slot;
            w_wr_data = w_v;
        end
    end

    // Saturating fitness total
    assign w_fit_sum   = {1'b0, r_fit} + (cgp_pkg::FIT_W + 1)'(r_match);
    assign w_fit_total = w_fit_sum[cgp_pkg::FIT_W] ? cgp_pkg::FIT_MAX
                                                    : w_fit_sum[cgp_pkg::FIT_W-1:0];

    // Sequencer, configuration, valid bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_ni <= cgp_pkg::RST_NUM_INPUTS;
            r_cfg_nn <= cgp_pkg::RST_NUM_NODES;
            r_cfg_no <= cgp_pkg::RST_NUM_OUTPUTS;
            r_omode  <= 1'b0;
            r_vld    <= '0;
            r_fit    <= '0;
            r_ovld   <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cgp_pkg::REG_NUM_INPUTS:  r_cfg_ni <= i_cfg_data[3:0];
                    cgp_pkg::REG_NUM_NODES:   r_cfg_nn <= i_cfg_data;
                    cgp_pkg::REG_NUM_OUTPUTS: r_cfg_no <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end

            // Drop the result once taken, unless a new one loads in the same cycle
            if (w_out_acc && !w_load) begin
                r_ovld <= 1'b0;
            end

            r_p1_vld <= (r_state == S_RUN);
            r_p2_vld <= r_p1_vld;

            // Collect output picks
            if (r_p2_vld && r_p2_out) begin
                r_obits[r_p2_oidx] <= w_a;
                if (w_a == r_ebits[r_p2_oidx]) begin
                    r_match <= r_match + cgp_pkg::NOW'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_data.kind == cgp_pkg::KIND_EVAL)) begin
                        r_state <= S_LOAD;
                        r_ni    <= w_ni;
                        r_nn    <= w_nn;
                        r_no    <= w_no;
                        r_jcnt  <= '0;
                        r_ibits <= i_data.input_bits;
                        r_ebits <= i_data.expected_bits;
                        r_last  <= i_data.last_row;
                        r_obits <= '0;
                        r_match <= '0;
                    end
                end
                S_LOAD: begin
                    r_jcnt <= r_jcnt + NIW'(1);
                    if (r_jcnt == r_ni - NIW'(1)) begin
                        r_state <= S_RUN;
                        r_kcnt  <= '0;
                        r_omode <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (!r_omode) begin
                        if (r_kcnt == r_nn - NNW'(1)) begin
                            r_omode <= 1'b1;
                            r_orow  <= GRW'(r_nn);
                            r_obank <= cgp_pkg::BANK_SRC_A;
                            r_ocnt  <= '0;
                        end else begin
                            r_kcnt <= r_kcnt + NNW'(1);
                        end
                    end else begin
                        if (cgp_pkg::NOW'(r_ocnt) == r_no - cgp_pkg::NOW'(1)) begin
                            r_state <= S_DRAIN;
                        end
                        r_ocnt <= r_ocnt + cgp_pkg::OCW'(1);
                        if (r_obank == cgp_pkg::BANK_FUNC) begin
                            r_obank <= cgp_pkg::BANK_SRC_A;
                            r_orow  <= r_orow + GRW'(1);
                        end else begin
                            r_obank <= r_obank + 2'd1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_load) begin
                        r_state                     <= S_IDLE;
                        r_ovld                      <= 1'b1;
                        r_odata.output_bits         <= r_obits;
                        r_odata.row_matches         <= r_match;
                        r_odata.fitness_total       <= w_fit_total;
                        r_odata.pass_done           <= r_last;
                        r_fit                       <= r_last ? '0 : w_fit_total;
                    end
                end
            endcase
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_out    <= r_omode;
        r_p1_bank   <= r_obank;
        r_p1_oidx   <= r_ocnt;
        r_p1_slot   <= SW'(r_ni) + SW'(r_kcnt);

        r_p2_out    <= r_p1_out;
        r_p2_oidx   <= r_p1_oidx;
        r_p2_slot   <= r_p1_slot;
        r_p2_func   <= w_gq[2];
        r_p2_rng_a  <= w_rng_a;
        r_p2_rng_b  <= w_rng_b;
        r_p2_vbit_a <= w_rng_a ? r_vld[w_rda] : 1'b0;
        r_p2_vbit_b <= w_rng_b ? r_vld[w_rdb] : 1'b0;
        r_p2_hit_a  <= w_wr_en && (w_rda == w_wr_addr);
        r_p2_hit_b  <= w_wr_en && (w_rdb == w_wr_addr);
        r_p2_fwd    <= w_wr_data;
    end

`ifndef ASSERT_OFF
    // A new item only enters with the node pipeline empty
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (!r_p1_vld && !r_p2_vld))
        else $error("item transferred while node pipeline busy");

    // Node results never land on this row's input slots
    a_node_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_vld && !r_p2_out) |-> (r_p2_slot >= SW'(r_ni)))
        else $error("node result written over an input slot");

    // The last row of a pass clears the fitness total
    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_last) |=> (r_fit == '0))
        else $error("fitness total not cleared after last row");

    // Pipeline stages run only while evaluating
    a_pipe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> ((r_state == S_RUN) || (r_state == S_DRAIN)))
        else $error("node pipeline active outside evaluation");
`endif

endmodule

FILE: sim/cgp_row_checker.sv
// Scoreboard for the CGP gate-array evaluator: tracks genome, value slots and fitness.
// Watches the input, output and register ports; depends on cgp_pkg only.
`timescale 1ns / 1ps

module cgp_row_checker
    import cgp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_item               i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_item              i_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int unsigned GENOME_DEPTH = 3 * DEF_MAX_NODES + DEF_MAX_OUTPUTS;
    localparam int unsigned SLOT_DEPTH   = DEF_MAX_INPUTS + DEF_MAX_NODES;

    // Shadow copy of the block's registers and stores
    logic [3:0]        shape_ni;
    logic [6:0]        shape_nn;
    logic [3:0]        shape_no;
    logic [GENE_W-1:0] genome [GENOME_DEPTH];
    logic              slot_val [SLOT_DEPTH];
    int unsigned       fit_acc;
    t_out_item         rows_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Out-of-range slot indexes read as zero
    function automatic logic slot_at(input int unsigned idx);
        return (idx < SLOT_DEPTH) ? slot_val[idx] : 1'b0;
    endfunction

    // Evaluate one truth-table row and advance the running fitness
    function automatic t_out_item eval_row(input t_in_item it);
        int unsigned ni, nn, no, k, hits, total;
        logic a, b, v, pick;
        logic [GENE_W-1:0] fn;
        t_out_item r;
        ni = clamp_count(shape_ni, DEF_MAX_INPUTS);
        nn = clamp_count(shape_nn, DEF_MAX_NODES);
        no = clamp_count(shape_no, DEF_MAX_OUTPUTS);
        for (k = 0; k < ni; k++) slot_val[k] = it.input_bits[k];
        // Nodes in order; forward references see whatever the slot holds now
        for (k = 0; k < nn; k++) begin
            a  = slot_at(genome[3 * k]);
            b  = slot_at(genome[3 * k + 1]);
            fn = genome[3 * k + 2];
            case (fn)
                FN_AND:  v = a & b;
                FN_OR:   v = a | b;
                FN_NOT:  v = ~a;
                default: v = a ^ b;
            endcase
            slot_val[ni + k] = v;
        end
        r    = '0;
        hits = 0;
        for (k = 0; k < no; k++) begin
            pick = slot_at(genome[3 * nn + k]);
            r.output_bits[k] = pick;
            if (pick == it.expected_bits[k]) hits++;
        end
        // Saturate the total, clear the accumulator after the last row
        total = fit_acc + hits;
        if (total > FIT_MAX) total = FIT_MAX;
        fit_acc = it.last_row ? 0 : total;
        r.row_matches   = NOW'(hits);
        r.fitness_total = FIT_W'(total);
        r.pass_done     = it.last_row;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shape_ni = RST_NUM_INPUTS;
            shape_nn = RST_NUM_NODES;
            shape_no = RST_NUM_OUTPUTS;
            foreach (genome[i]) genome[i] = '0;
            foreach (slot_val[i]) slot_val[i] = 1'b1;
            fit_acc = 0;
            rows_due.delete();
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_INPUTS:  shape_ni = i_cfg_data[3:0];
                    REG_NUM_NODES:   shape_nn = i_cfg_data[6:0];
                    REG_NUM_OUTPUTS: shape_no = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // Input transfer: store a gene or predict a row
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.kind == KIND_WRITE) begin
                    if (i_in_data.gene_addr < GENOME_DEPTH)
                        genome[i_in_data.gene_addr] = i_in_data.gene_value;
                end else begin
                    rows_due.push_back(eval_row(i_in_data));
                end
            end
            // Output transfer: compare against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (rows_due.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: %h", i_out_data));
                end else begin
                    want = rows_due.pop_front();
                    if (i_out_data.output_bits !== want.output_bits)
                        report_mismatch($sformatf("output_bits got %h want %h",
                            i_out_data.output_bits, want.output_bits));
                    if (i_out_data.row_matches !== want.row_matches)
                        report_mismatch($sformatf("row_matches got %0d want %0d",
                            i_out_data.row_matches, want.row_matches));
                    if (i_out_data.fitness_total !== want.fitness_total)
                        report_mismatch($sformatf("fitness_total got %0d want %0d",
                            i_out_data.fitness_total, want.fitness_total));
                    if (i_out_data.pass_done !== want.pass_done)
                        report_mismatch($sformatf("pass_done got %b want %b",
                            i_out_data.pass_done, want.pass_done));
                end
            end
        end
        o_pending = rows_due.size();
    end

endmodule

FILE: sim/tb_cgp_gate_array_evaluator_top.sv
// Stimulus and verdict for cgp_gate_array_evaluator_top: genome loads, row passes, shapes.
// Depends on cgp_pkg, the block itself and cgp_row_checker.
`timescale 1ns / 1ps

module tb_cgp_gate_array_evaluator_top;
    import cgp_pkg::*;

    localparam int unsigned ITEM_GOAL    = 450;
    localparam int unsigned SETTLE_CYC   = 100;
    localparam logic [GENE_W-1:0] FN_XOR_LO = 7'd0;
    localparam logic [GENE_W-1:0] FN_XOR_HI = 7'd127;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_item              i_data;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    n_fail;
    int                    n_pending;
    bit                    no_gaps;
    int unsigned           n_items;

    cgp_gate_array_evaluator_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cgp_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Random back-pressure on the result side
    always @(negedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(0, 99) < 37);
    end

    // Drive one transfer, with random idle cycles ahead of it unless no_gaps is set
    task automatic send_item(input t_in_item it);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 37) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic put_gene(input int unsigned addr, input logic [GENE_W-1:0] val);
        t_in_item it;
        it.kind          = KIND_WRITE;
        it.gene_addr     = ADDR_W'(addr);
        it.gene_value    = val;
        it.input_bits    = BITS_W'($urandom);
        it.expected_bits = BITS_W'($urandom);
        it.last_row      = 1'($urandom);
        send_item(it);
    endtask

    task automatic run_row(input logic [BITS_W-1:0] bits, input logic [BITS_W-1:0] want,
                           input logic last);
        t_in_item it;
        it.kind          = KIND_EVAL;
        it.gene_addr     = ADDR_W'($urandom);
        it.gene_value    = GENE_W'($urandom);
        it.input_bits    = bits;
        it.expected_bits = want;
        it.last_row      = last;
        send_item(it);
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic program_shape(input logic [3:0] ni, input logic [6:0] nn,
                                 input logic [3:0] no);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NUM_INPUTS;
        i_cfg_data <= CFG_DATA_W'(ni);
        @(negedge i_clk);
        i_cfg_idx  <= REG_NUM_NODES;
        i_cfg_data <= nn;
        @(negedge i_clk);
        i_cfg_idx  <= REG_NUM_OUTPUTS;
        i_cfg_data <= CFG_DATA_W'(no);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Mostly feed-forward sources; noise picks any index, forward or out of range
    function automatic logic [GENE_W-1:0] pick_source(input int unsigned limit,
                                                      input int unsigned noise);
        if ($urandom_range(0, 99) < noise) return GENE_W'($urandom_range(0, 127));
        return GENE_W'($urandom_range(0, limit - 1));
    endfunction

    function automatic logic [GENE_W-1:0] pick_function();
        case ($urandom_range(0, 4))
            0:       return FN_AND;
            1:       return FN_OR;
            2:       return FN_NOT;
            3:       return FN_XOR_LO;
            default: return GENE_W'($urandom_range(0, 127));
        endcase
    endfunction

    // Write a circuit; big arrays get only a handful of nodes rewritten unless full
    task automatic load_circuit(input int unsigned ni, input int unsigned nn,
                                input int unsigned no, input int unsigned noise,
                                input bit full);
        int unsigned k, n;
        if (full || nn <= 16) begin
            for (k = 0; k < nn; k++) begin
                put_gene(3 * k, pick_source(ni + k, noise));
                put_gene(3 * k + 1, pick_source(ni + k, noise));
                put_gene(3 * k + 2, pick_function());
            end
        end else begin
            for (n = 0; n < 8; n++) begin
                k = $urandom_range(0, nn - 1);
                put_gene(3 * k, pick_source(ni + k, noise));
                put_gene(3 * k + 1, pick_source(ni + k, noise));
                put_gene(3 * k + 2, pick_function());
            end
        end
        for (k = 0; k < no; k++) put_gene(3 * nn + k, pick_source(ni + nn, noise));
    endtask

    initial begin
        #(2_000_000);
        $display("** cgp_gate_array_evaluator_top: FAILED **");
        $finish;
    end

    initial begin
        int unsigned phase, rows, r, ni, nn, no;
        logic [3:0] ni_raw, no_raw;
        logic [6:0] nn_raw;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        no_gaps    = 1'b0;
        n_items    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole genome so no later read hits an unwritten gene
        load_circuit(DEF_MAX_INPUTS, DEF_MAX_NODES, DEF_MAX_OUTPUTS, 10, 1'b1);

        // Directed: input extremes, each gate function, forward and out-of-range sources
        run_row(8'h00, 8'h00, 1'b0);
        run_row(8'hFF, 8'hFF, 1'b0);
        run_row(8'h5A, 8'hA5, 1'b1);
        put_gene(200, FN_XOR_HI);
        put_gene(255, FN_XOR_LO);
        put_gene(0, 7'd0);
        put_gene(1, 7'd1);
        put_gene(3 * DEF_MAX_NODES, 7'd8);
        put_gene(2, FN_AND);
        run_row(8'h03, 8'h01, 1'b0);
        put_gene(2, FN_OR);
        run_row(8'h02, 8'h00, 1'b0);
        put_gene(2, FN_NOT);
        run_row(8'h01, 8'hFF, 1'b0);
        put_gene(2, FN_XOR_LO);
        run_row(8'h01, 8'h01, 1'b0);
        put_gene(2, FN_XOR_HI);
        run_row(8'h03, 8'h00, 1'b0);
        put_gene(0, 7'd71);
        run_row(8'hC3, 8'h55, 1'b0);
        run_row(8'h3C, 8'hAA, 1'b0);
        put_gene(1, 7'd72);
        put_gene(0, 7'd127);
        run_row(8'h81, 8'h7E, 1'b1);
        settle();

        // Phases: new shape (fixed for the first four, then random), new circuit, one truth-table pass
        phase   = 0;
        while (n_items < ITEM_GOAL) begin
            case (phase)
                0: begin ni_raw = 4'd0;  nn_raw = 7'd0;   no_raw = 4'd0;  end
                1: begin ni_raw = 4'd15; nn_raw = 7'd127; no_raw = 4'd15; end
                2: begin ni_raw = 4'd1;  nn_raw = 7'd1;   no_raw = 4'd1;  end
                3: begin ni_raw = 4'd8;  nn_raw = 7'd64;  no_raw = 4'd8;  end
                default: begin
                    ni_raw = 4'($urandom_range(0, 15));
                    no_raw = 4'($urandom_range(0, 15));
                    case ($urandom_range(0, 9))
                        0:       nn_raw = 7'($urandom_range(0, 127));
                        1:       nn_raw = 7'd64;
                        default: nn_raw = 7'($urandom_range(1, 16));
                    endcase
                end
            endcase
            ni = bounded(ni_raw, DEF_MAX_INPUTS);
            nn = bounded(nn_raw, DEF_MAX_NODES);
            no = bounded(no_raw, DEF_MAX_OUTPUTS);
            settle();
            no_gaps = (phase >= 3 && phase <= 5);
            program_shape(ni_raw, nn_raw, no_raw);
            load_circuit(ni, nn, no, (phase % 4 == 3) ? 40 : 8, 1'b0);
            rows = $urandom_range(3, 12);
            for (r = 0; r < rows; r++) begin
                if ($urandom_range(0, 99) < 12)
                    put_gene($urandom_range(0, 255), GENE_W'($urandom_range(0, 127)));
                run_row(BITS_W'($urandom), BITS_W'($urandom), r == rows - 1);
            end
            phase++;
        end
        no_gaps = 1'b0;
        settle();

        if (n_fail == 0 && n_pending == 0)
            $display("** cgp_gate_array_evaluator_top: PASSED **");
        else
            $display("** cgp_gate_array_evaluator_top: FAILED **");
        $finish;
    end

endmodule
